[rtl/core/mtp_pkg.sv]
`default_nettype none
package mtp_pkg;

    typedef enum logic [3:0] {
        PH_VER     = 4'd0,
        PH_INCNT   = 4'd1,
        PH_INTYPE  = 4'd2,
        PH_HEIGHT  = 4'd3,
        PH_EXCNT   = 4'd4,
        PH_EXTAG   = 4'd5,
        PH_EXVAR   = 4'd6,
        PH_EXLEN   = 4'd7,
        PH_EXSKIP  = 4'd8,
        PH_OUTCNT  = 4'd9,
        PH_OUTTYPE = 4'd10,
        PH_OUTVER  = 4'd11,
        PH_KEY     = 4'd12,
        PH_OUTSKIP = 4'd13,
        PH_HF      = 4'd14,
        PH_END     = 4'd15
    } t_phase;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_VERSION    = 4'd1;
    localparam logic [3:0] ST_INPUT      = 4'd2;
    localparam logic [3:0] ST_EXTRAS     = 4'd3;
    localparam logic [3:0] ST_EXTRA_TAG  = 4'd4;
    localparam logic [3:0] ST_OUT_COUNT  = 4'd5;
    localparam logic [3:0] ST_OUT_TYPE   = 4'd6;
    localparam logic [3:0] ST_OUT_VER    = 4'd7;
    localparam logic [3:0] ST_HARDFORK   = 4'd8;
    localparam logic [3:0] ST_TRUNCATED  = 4'd9;
    localparam logic [3:0] ST_OVERFLOW   = 4'd10;
    localparam logic [3:0] ST_NONCANON   = 4'd11;
    localparam logic [3:0] ST_TOO_LONG   = 4'd12;

    localparam logic [7:0] TAG_LEN_A     = 8'd11;
    localparam logic [7:0] TAG_LEN_B     = 8'd19;
    localparam logic [7:0] TAG_LEN_C     = 8'd21;
    localparam logic [7:0] TAG_VAR_A     = 8'd14;
    localparam logic [7:0] TAG_VAR_B     = 8'd15;
    localparam logic [7:0] TAG_VAR_C     = 8'd16;
    localparam logic [7:0] TAG_VAR_D     = 8'd78;
    localparam logic [7:0] TAG_VAR_KEY   = 8'd18;
    localparam logic [7:0] TAG_KEY       = 8'd22;

    localparam logic [7:0] OUT_TYPE_BYTE = 8'd63;
    localparam logic [7:0] KEY_SKIP      = 8'd32;
    localparam logic [7:0] OUT_SKIP      = 8'd17;

    localparam logic [1:0] REG_VERSION   = 2'd0;
    localparam logic [1:0] REG_EXTRAS    = 2'd1;
    localparam logic [1:0] REG_OUTPUTS   = 2'd2;
    localparam logic [1:0] REG_HARDFORK  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in;

    typedef struct packed {
        logic       key_valid;
        logic [4:0] output_index;
        logic [1:0] key_select;
        logic [4:0] key_byte_index;
        logic [7:0] key_byte;
        logic       done_res;
        logic [3:0] status;
        logic [5:0] outs_declared;
    } t_res;

endpackage
`default_nettype wire

[rtl/core/mtp_stream_if.sv]
`default_nettype none
interface mtp_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/core/mtp_parser.sv]
`default_nettype none
module mtp_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  mtp_pkg::t_in       i_item,
    input  wire logic [6:0]    i_exp_version,
    input  wire logic [10:0]   i_max_extras,
    input  wire logic [8:0]    i_out_limit,
    input  wire logic [7:0]    i_exp_hardfork,
    output logic               o_res_valid,
    output mtp_pkg::t_res      o_res
);
    import mtp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [63:0] r_vval, n_vval;
    logic [3:0]  r_vlen, n_vlen;
    logic [63:0] r_skip, n_skip;
    logic [10:0] r_extras, n_extras;
    logic [1:0]  r_sub, n_sub;
    logic [5:0]  r_outs, n_outs;
    logic [4:0]  r_outnum, n_outnum;
    logic [1:0]  r_kpart, n_kpart;
    logic [4:0]  r_koff, n_koff;
    logic [5:0]  r_decl, n_decl;
    logic [3:0]  r_err, n_err;

    logic [7:0]  b;
    logic [6:0]  vsh;
    logic [63:0] vnew;
    logic [3:0]  verr;
    logic        vdone;
    logic        is_var;
    logic        kv;
    logic [10:0] extras_dec;
    logic [63:0] skip_dec;
    logic [5:0]  outs_dec;

    assign b          = i_item.data_byte;
    assign vsh        = 7'(r_vlen) * 7'd7;
    assign vnew       = r_vval | (64'(b[6:0]) << vsh);
    assign extras_dec = r_extras - 11'd1;
    assign skip_dec   = r_skip - 64'd1;
    assign outs_dec   = r_outs - 6'd1;

    always_comb begin
        verr  = ST_OK;
        vdone = 1'b0;
        if (r_vlen == 4'd9 && b[6:1] != 6'd0) begin
            verr = ST_OVERFLOW;
        end else if (!b[7]) begin
            if (r_vlen != 4'd0 && b[6:0] == 7'd0) begin
                verr = ST_NONCANON;
            end else begin
                vdone = 1'b1;
            end
        end else if (r_vlen == 4'd9) begin
            verr = ST_TOO_LONG;
        end
    end

    always_comb begin
        case (r_phase) inside
            PH_VER, PH_INCNT, PH_HEIGHT, PH_EXCNT, PH_EXVAR, PH_EXLEN, PH_OUTCNT: is_var = 1'b1;
            default: is_var = 1'b0;
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_vval   = r_vval;
        n_vlen   = r_vlen;
        n_skip   = r_skip;
        n_extras = r_extras;
        n_sub    = r_sub;
        n_outs   = r_outs;
        n_outnum = r_outnum;
        n_kpart  = r_kpart;
        n_koff   = r_koff;
        n_decl   = r_decl;
        n_err    = r_err;
        kv       = 1'b0;
        o_res    = '0;
        o_res_valid = 1'b0;

        if (i_accept) begin
            if (r_err == ST_OK) begin
                if (is_var) begin
                    if (verr != ST_OK) begin
                        n_err = verr;
                    end else if (!vdone) begin
                        n_vval = vnew;
                        n_vlen = r_vlen + 4'd1;
                    end else begin
                        n_vval = '0;
                        n_vlen = '0;
                        case (r_phase)
                            PH_VER: begin
                                if (vnew != 64'(i_exp_version)) n_err = ST_VERSION;
                                else n_phase = PH_INCNT;
                            end
                            PH_INCNT: begin
                                if (vnew != 64'd1) n_err = ST_INPUT;
                                else n_phase = PH_INTYPE;
                            end
                            PH_HEIGHT: n_phase = PH_EXCNT;
                            PH_EXCNT: begin
                                if (vnew > 64'(i_max_extras)) begin
                                    n_err = ST_EXTRAS;
                                end else begin
                                    n_extras = vnew[10:0];
                                    n_phase  = (vnew[10:0] == 11'd0) ? PH_OUTCNT : PH_EXTAG;
                                end
                            end
                            PH_EXVAR: begin
                                if (r_sub == 2'd1) begin
                                    n_sub   = 2'd2;
                                    n_skip  = 64'(KEY_SKIP);
                                    n_phase = PH_EXSKIP;
                                end else begin
                                    n_sub    = 2'd0;
                                    n_extras = extras_dec;
                                    n_phase  = (extras_dec == 11'd0) ? PH_OUTCNT : PH_EXTAG;
                                end
                            end
                            PH_EXLEN: begin
                                if (vnew == 64'd0) begin
                                    n_sub    = 2'd0;
                                    n_extras = extras_dec;
                                    n_phase  = (extras_dec == 11'd0) ? PH_OUTCNT : PH_EXTAG;
                                end else begin
                                    n_skip  = vnew;
                                    n_phase = PH_EXSKIP;
                                end
                            end
                            PH_OUTCNT: begin
                                if (vnew > 64'(i_out_limit)) begin
                                    n_err = ST_OUT_COUNT;
                                end else begin
                                    n_decl   = vnew[5:0];
                                    n_outs   = vnew[5:0];
                                    n_outnum = '0;
                                    n_phase  = (vnew[5:0] == 6'd0) ? PH_HF : PH_OUTTYPE;
                                end
                            end
                            default: n_err = ST_HARDFORK;
                        endcase
                    end
                end else begin
                    case (r_phase)
                        PH_INTYPE: begin
                            if (b != 8'd0) n_err = ST_INPUT;
                            else n_phase = PH_HEIGHT;
                        end
                        PH_EXTAG: begin
                            n_sub = 2'd0;
                            if (b == TAG_LEN_A || b == TAG_LEN_B || b == TAG_LEN_C) begin
                                n_phase = PH_EXLEN;
                            end else if (b == TAG_VAR_A || b == TAG_VAR_B || b == TAG_VAR_C
                                         || b == TAG_VAR_D) begin
                                n_phase = PH_EXVAR;
                            end else if (b == TAG_VAR_KEY) begin
                                n_sub   = 2'd1;
                                n_phase = PH_EXVAR;
                            end else if (b == TAG_KEY) begin
                                n_skip  = 64'(KEY_SKIP);
                                n_phase = PH_EXSKIP;
                            end else begin
                                n_err = ST_EXTRA_TAG;
                            end
                        end
                        PH_EXSKIP: begin
                            n_skip = skip_dec;
                            if (skip_dec == 64'd0) begin
                                if (r_sub == 2'd2) begin
                                    n_sub   = 2'd3;
                                    n_phase = PH_EXVAR;
                                end else begin
                                    n_sub    = 2'd0;
                                    n_extras = extras_dec;
                                    n_phase  = (extras_dec == 11'd0) ? PH_OUTCNT : PH_EXTAG;
                                end
                            end
                        end
                        PH_OUTTYPE: begin
                            if (b != OUT_TYPE_BYTE) n_err = ST_OUT_TYPE;
                            else n_phase = PH_OUTVER;
                        end
                        PH_OUTVER: begin
                            if (b != 8'd0) begin
                                n_err = ST_OUT_VER;
                            end else begin
                                n_kpart = '0;
                                n_koff  = '0;
                                n_phase = PH_KEY;
                            end
                        end
                        PH_KEY: begin
                            kv = 1'b1;
                            n_koff = r_koff + 5'd1;
                            if (r_koff == 5'd31) begin
                                n_kpart = r_kpart + 2'd1;
                                if (r_kpart == 2'd3) begin
                                    n_skip  = 64'(OUT_SKIP);
                                    n_phase = PH_OUTSKIP;
                                end
                            end
                        end
                        PH_OUTSKIP: begin
                            n_skip = skip_dec;
                            if (skip_dec == 64'd0) begin
                                n_outs   = outs_dec;
                                n_outnum = r_outnum + 5'd1;
                                n_phase  = (outs_dec == 6'd0) ? PH_HF : PH_OUTTYPE;
                            end
                        end
                        PH_HF: begin
                            if (b != i_exp_hardfork) n_err = ST_HARDFORK;
                            else n_phase = PH_END;
                        end
                        default: n_err = ST_HARDFORK;
                    endcase
                end
            end

            if (kv) begin
                o_res.key_valid      = 1'b1;
                o_res.output_index   = r_outnum;
                o_res.key_select     = r_kpart;
                o_res.key_byte_index = r_koff;
                o_res.key_byte       = b;
            end
            if (i_item.last) begin
                o_res.done_res      = 1'b1;
                o_res.status        = (n_err != ST_OK) ? n_err :
                                      (n_phase != PH_END) ? ST_TRUNCATED : ST_OK;
                o_res.outs_declared = n_decl;
                n_phase  = PH_VER;
                n_vval   = '0;
                n_vlen   = '0;
                n_skip   = '0;
                n_extras = '0;
                n_sub    = '0;
                n_outs   = '0;
                n_outnum = '0;
                n_kpart  = '0;
                n_koff   = '0;
                n_decl   = '0;
                n_err    = ST_OK;
            end
            o_res_valid = kv || i_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_VER;
            r_vval   <= '0;
            r_vlen   <= '0;
            r_skip   <= '0;
            r_extras <= '0;
            r_sub    <= '0;
            r_outs   <= '0;
            r_outnum <= '0;
            r_kpart  <= '0;
            r_koff   <= '0;
            r_decl   <= '0;
            r_err    <= ST_OK;
        end else begin
            r_phase  <= n_phase;
            r_vval   <= n_vval;
            r_vlen   <= n_vlen;
            r_skip   <= n_skip;
            r_extras <= n_extras;
            r_sub    <= n_sub;
            r_outs   <= n_outs;
            r_outnum <= n_outnum;
            r_kpart  <= n_kpart;
            r_koff   <= n_koff;
            r_decl   <= n_decl;
            r_err    <= n_err;
        end
    end
endmodule
`default_nettype wire

[rtl/core/mtp_out_buf.sv]
`default_nettype none
module mtp_out_buf (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  mtp_pkg::t_res  i_res,
    output logic           o_space,
    mtp_stream_if.source   o_res
);
    import mtp_pkg::*;

    logic r_out_valid, n_out_valid;
    logic r_skid_valid, n_skid_valid;
    t_res r_out, n_out;
    t_res r_skid, n_skid;
    logic pop;

    assign pop           = r_out_valid && o_res.ready;
    assign o_space       = !r_skid_valid;
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (pop) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_valid || pop) begin
                n_out       = i_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_res;
                n_skid_valid = 1'b1;
            end
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end
endmodule
`default_nettype wire

[rtl/core/miner_tx_prefix_parser_top.sv]
// Miner-transaction prefix parser.
// Input channel i_in carries one prefix byte per transaction with a last flag
// on the final byte. Output channel o_res carries at most one result per input
// byte: a key byte of an output (key_valid), a final report (done_res with
// status and outs_declared), or both when the last byte is also a key byte.
// Bytes that produce neither give no result.
// The result of an accepted byte is registered before it appears on o_res.
// Throughput: one byte per cycle while i_in is ready; the whole parse step sits
// between the state registers and the output register. A two-entry output stage
// (register plus skid) keeps i_in ready while one result waits; i_in.ready
// falls only when both entries are full, and rises once o_res takes a result.
// Registers sit on an APB port at byte addresses 0, 4, 8 and 12: expected
// version, extras limit, output limit, expected hardfork byte. Write them only
// while the block is idle. pready is tied high.
// Reset (synchronous, active low) clears the parser to the start of a prefix,
// empties the output stage and loads the register defaults. After each last
// byte the parser returns to the start of a new prefix by itself.
`default_nettype none
module miner_tx_prefix_parser_top #(
    parameter int MAX_OUTPUTS_BOUND = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    mtp_stream_if.sink       i_in,
    mtp_stream_if.source     o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mtp_pkg::*;

    localparam logic [8:0] BOUND = 9'(MAX_OUTPUTS_BOUND);

    logic [6:0]  r_exp_version;
    logic [10:0] r_max_extras;
    logic [5:0]  r_max_outputs;
    logic [7:0]  r_exp_hardfork;
    logic [8:0]  out_limit;
    logic        accept;
    logic        space;
    logic        res_valid;
    t_res        res;
    logic        wr_en;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign out_limit = ({3'b0, r_max_outputs} < BOUND) ? {3'b0, r_max_outputs} : BOUND;
    assign i_in.ready = space;
    assign accept    = i_in.valid && space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_version  <= 7'd4;
            r_max_extras   <= 11'd1024;
            r_max_outputs  <= 6'd32;
            r_exp_hardfork <= 8'd6;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_VERSION:  r_exp_version  <= pwdata[6:0];
                REG_EXTRAS:   r_max_extras   <= pwdata[10:0];
                REG_OUTPUTS:  r_max_outputs  <= pwdata[5:0];
                REG_HARDFORK: r_exp_hardfork <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_VERSION:  prdata = 32'(r_exp_version);
            REG_EXTRAS:   prdata = 32'(r_max_extras);
            REG_OUTPUTS:  prdata = 32'(r_max_outputs);
            REG_HARDFORK: prdata = 32'(r_exp_hardfork);
            default:      prdata = '0;
        endcase
    end

    mtp_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_item         (i_in.payload),
        .i_exp_version  (r_exp_version),
        .i_max_extras   (r_max_extras),
        .i_out_limit    (out_limit),
        .i_exp_hardfork (r_exp_hardfork),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    mtp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_space (space),
        .o_res   (o_res)
    );

`ifndef NO_ASSERTIONS
    a_key_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.payload.key_valid |->
            o_res.payload.output_index == 5'd0 && o_res.payload.key_select == 2'd0
            && o_res.payload.key_byte_index == 5'd0 && o_res.payload.key_byte == 8'd0)
        else $error("key fields set without key byte");
    a_done_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.payload.done_res |->
            o_res.payload.status == ST_OK && o_res.payload.outs_declared == 6'd0)
        else $error("report fields set without done");
    a_result_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.payload.key_valid || o_res.payload.done_res)
        else $error("empty result");
    a_ready_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> i_in.ready)
        else $error("input not ready after reset");
`endif
endmodule
`default_nettype wire

[dv/tb_miner_tx_prefix_parser_top.sv]
`default_nettype none
module tb_miner_tx_prefix_parser_top;
    import mtp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mtp_stream_if #(.T(t_in))  in_if ();
    mtp_stream_if #(.T(t_res)) res_if ();

    miner_tx_prefix_parser_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // parser mirror
    logic [6:0]  cfg_version;
    logic [10:0] cfg_extras;
    logic [5:0]  cfg_outputs;
    logic [7:0]  cfg_hardfork;

    t_phase      m_phase;
    logic [63:0] m_vval;
    int unsigned m_vshift, m_vlen;
    logic [63:0] m_skip;
    logic [10:0] m_extras_left;
    logic [1:0]  m_substep;
    logic [5:0]  m_outs_left;
    logic [4:0]  m_out_num;
    logic [1:0]  m_key_part;
    logic [4:0]  m_key_off;
    logic [5:0]  m_declared;
    logic [3:0]  m_err;

    t_res        pending_results[$];
    t_in         byte_stream[$];
    int          fail_count;
    int          results_seen;
    int          prefixes_sent;
    logic        hold_off;

    function automatic void parser_clear();
        m_phase = PH_VER;
        m_vval = '0; m_vshift = 0; m_vlen = 0; m_skip = '0;
        m_extras_left = '0; m_substep = '0; m_outs_left = '0; m_out_num = '0;
        m_key_part = '0; m_key_off = '0; m_declared = '0; m_err = ST_OK;
    endfunction

    function automatic bit varint_take(logic [7:0] b);
        int unsigned need;
        logic [63:0] t;
        if (m_vshift == 63 && (b & 8'h7e) != 0) begin
            m_err = ST_OVERFLOW;
            return 0;
        end
        if (m_vshift < 64) m_vval |= 64'(b[6:0]) << m_vshift;
        m_vlen++;
        if (!b[7]) begin
            need = 1;
            t = m_vval;
            while (t >= 64'h80) begin
                t >>= 7;
                need++;
            end
            m_vshift = 0;
            if (m_vlen != need) begin
                m_err = ST_NONCANON;
                return 0;
            end
            m_vlen = 0;
            return 1;
        end
        if (m_vlen >= 10) begin
            m_err = ST_TOO_LONG;
            return 0;
        end
        m_vshift += 7;
        return 0;
    endfunction

    function automatic void extra_finish();
        m_substep = 0;
        m_extras_left = m_extras_left - 11'd1;
        m_phase = (m_extras_left == 0) ? PH_OUTCNT : PH_EXTAG;
    endfunction

    function automatic void parse_byte(logic [7:0] b, ref t_res r);
        logic [63:0] v;
        int unsigned lim;
        case (m_phase)
            PH_VER: if (varint_take(b)) begin
                v = m_vval; m_vval = 0;
                if (v != 64'(cfg_version)) m_err = ST_VERSION; else m_phase = PH_INCNT;
            end
            PH_INCNT: if (varint_take(b)) begin
                v = m_vval; m_vval = 0;
                if (v != 1) m_err = ST_INPUT; else m_phase = PH_INTYPE;
            end
            PH_INTYPE: if (b != 0) m_err = ST_INPUT; else m_phase = PH_HEIGHT;
            PH_HEIGHT: if (varint_take(b)) begin
                m_vval = 0; m_phase = PH_EXCNT;
            end
            PH_EXCNT: if (varint_take(b)) begin
                v = m_vval; m_vval = 0;
                if (v > 64'(cfg_extras)) m_err = ST_EXTRAS;
                else begin
                    m_extras_left = v[10:0];
                    m_phase = (m_extras_left == 0) ? PH_OUTCNT : PH_EXTAG;
                end
            end
            PH_EXTAG: begin
                m_substep = 0;
                if (b == TAG_LEN_A || b == TAG_LEN_B || b == TAG_LEN_C) m_phase = PH_EXLEN;
                else if (b == TAG_VAR_A || b == TAG_VAR_B || b == TAG_VAR_C || b == TAG_VAR_D)
                    m_phase = PH_EXVAR;
                else if (b == TAG_VAR_KEY) begin
                    m_substep = 1; m_phase = PH_EXVAR;
                end else if (b == TAG_KEY) begin
                    m_skip = 32; m_phase = PH_EXSKIP;
                end else m_err = ST_EXTRA_TAG;
            end
            PH_EXVAR: if (varint_take(b)) begin
                m_vval = 0;
                if (m_substep == 1) begin
                    m_substep = 2; m_skip = 32; m_phase = PH_EXSKIP;
                end else extra_finish();
            end
            PH_EXLEN: if (varint_take(b)) begin
                v = m_vval; m_vval = 0;
                if (v == 0) extra_finish();
                else begin
                    m_skip = v; m_phase = PH_EXSKIP;
                end
            end
            PH_EXSKIP: begin
                m_skip--;
                if (m_skip == 0) begin
                    if (m_substep == 2) begin
                        m_substep = 3; m_phase = PH_EXVAR;
                    end else extra_finish();
                end
            end
            PH_OUTCNT: begin
                lim = (cfg_outputs < 32) ? cfg_outputs : 32;
                if (varint_take(b)) begin
                    v = m_vval; m_vval = 0;
                    if (v > 64'(lim)) m_err = ST_OUT_COUNT;
                    else begin
                        m_declared = v[5:0];
                        m_outs_left = m_declared;
                        m_out_num = 0;
                        m_phase = (m_outs_left == 0) ? PH_HF : PH_OUTTYPE;
                    end
                end
            end
            PH_OUTTYPE: if (b != OUT_TYPE_BYTE) m_err = ST_OUT_TYPE; else m_phase = PH_OUTVER;
            PH_OUTVER: begin
                if (b != 0) m_err = ST_OUT_VER;
                else begin
                    m_key_part = 0; m_key_off = 0; m_phase = PH_KEY;
                end
            end
            PH_KEY: begin
                r.key_valid = 1;
                r.output_index = m_out_num;
                r.key_select = m_key_part;
                r.key_byte_index = m_key_off;
                r.key_byte = b;
                if (m_key_off < 31) m_key_off++;
                else begin
                    m_key_off = 0;
                    if (m_key_part < 3) m_key_part++;
                    else begin
                        m_key_part = 0; m_skip = 17; m_phase = PH_OUTSKIP;
                    end
                end
            end
            PH_OUTSKIP: begin
                m_skip--;
                if (m_skip == 0) begin
                    m_outs_left = m_outs_left - 6'd1;
                    m_out_num = m_out_num + 5'd1;
                    m_phase = (m_outs_left == 0) ? PH_HF : PH_OUTTYPE;
                end
            end
            PH_HF: if (b != cfg_hardfork) m_err = ST_HARDFORK; else m_phase = PH_END;
            default: m_err = ST_HARDFORK;
        endcase
    endfunction

    function automatic void predict_byte(t_in it);
        t_res r;
        r = '0;
        if (m_err == ST_OK) parse_byte(it.data_byte, r);
        if (it.last) begin
            r.done_res = 1;
            r.status = (m_err == ST_OK && m_phase != PH_END) ? ST_TRUNCATED : m_err;
            r.outs_declared = m_declared;
            parser_clear();
        end
        if (r.key_valid || r.done_res) pending_results.insert(pending_results.size(), r);
    endfunction

    // prefix builders
    function automatic void put(logic [7:0] b);
        t_in it;
        it.data_byte = b;
        it.last = 0;
        byte_stream.insert(byte_stream.size(), it);
    endfunction

    function automatic void put_varint(logic [63:0] v);
        while (v >= 64'h80) begin
            put({1'b1, v[6:0]});
            v >>= 7;
        end
        put({1'b0, v[6:0]});
    endfunction

    function automatic void end_prefix();
        t_in it;
        it = byte_stream[$];
        it.last = 1;
        byte_stream[byte_stream.size() - 1] = it;
    endfunction

    function automatic logic [63:0] rand_varint_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 127);
            1: return $urandom_range(128, 20000);
            2: return {$urandom, $urandom};
            default: return 64'hffff_ffff_ffff_ffff;
        endcase
    endfunction

    function automatic void build_prefix(int n_outs, int n_extras);
        int len;
        put_varint(cfg_version);
        put_varint(1);
        put(0);
        put_varint(rand_varint_value());
        put_varint(n_extras);
        for (int e = 0; e < n_extras; e++) begin
            case ($urandom_range(0, 3))
                0: begin
                    put(TAG_LEN_A);
                    len = $urandom_range(0, 4);
                    put_varint(len);
                    for (int k = 0; k < len; k++) put(8'($urandom));
                end
                1: begin
                    put(TAG_VAR_D);
                    put_varint(rand_varint_value());
                end
                2: begin
                    put(TAG_VAR_KEY);
                    put_varint($urandom_range(0, 300));
                    for (int k = 0; k < 32; k++) put(8'($urandom));
                    put_varint($urandom_range(0, 300));
                end
                default: begin
                    put(TAG_KEY);
                    for (int k = 0; k < 32; k++) put(8'($urandom));
                end
            endcase
        end
        put_varint(n_outs);
        for (int o = 0; o < n_outs; o++) begin
            put(OUT_TYPE_BYTE);
            put(0);
            for (int k = 0; k < 128 + 17; k++) put(8'($urandom));
        end
        put(cfg_hardfork);
    endfunction

    // random damage of a well-formed prefix
    function automatic void damage_tail(int start);
        int pos;
        t_in it;
        pos = $urandom_range(start, byte_stream.size() - 1);
        case ($urandom_range(0, 2))
            0: begin
                it = byte_stream[pos];
                it.data_byte = 8'($urandom);
                byte_stream[pos] = it;
            end
            1: while (byte_stream.size() > pos + 1) void'(byte_stream.pop_back());
            default: put(8'($urandom));
        endcase
    endfunction

    // clock and timeout
    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // sink with random stalls, a few long ones, and one long hold-off
    initial begin
        int stall_left;
        stall_left = 0;
        res_if.ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off) res_if.ready <= 0;
            else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 0;
            end else if ($urandom_range(0, 19) == 0) begin
                stall_left = $urandom_range(5, 30);
                res_if.ready <= 0;
            end else res_if.ready <= ($urandom_range(0, 9) < 7);
        end
    end

    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result %p", res_if.payload);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (res_if.payload.key_valid !== exp_r.key_valid) begin
                    $error("key_valid exp %0d got %0d", exp_r.key_valid,
                           res_if.payload.key_valid);
                    fail_count++;
                end
                if (res_if.payload.output_index !== exp_r.output_index) begin
                    $error("output_index exp %0d got %0d", exp_r.output_index,
                           res_if.payload.output_index);
                    fail_count++;
                end
                if (res_if.payload.key_select !== exp_r.key_select) begin
                    $error("key_select exp %0d got %0d", exp_r.key_select,
                           res_if.payload.key_select);
                    fail_count++;
                end
                if (res_if.payload.key_byte_index !== exp_r.key_byte_index) begin
                    $error("key_byte_index exp %0d got %0d", exp_r.key_byte_index,
                           res_if.payload.key_byte_index);
                    fail_count++;
                end
                if (res_if.payload.key_byte !== exp_r.key_byte) begin
                    $error("key_byte exp %0h got %0h", exp_r.key_byte,
                           res_if.payload.key_byte);
                    fail_count++;
                end
                if (res_if.payload.done_res !== exp_r.done_res) begin
                    $error("done_res exp %0d got %0d", exp_r.done_res,
                           res_if.payload.done_res);
                    fail_count++;
                end
                if (res_if.payload.status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, res_if.payload.status);
                    fail_count++;
                end
                if (res_if.payload.outs_declared !== exp_r.outs_declared) begin
                    $error("outs_declared exp %0d got %0d", exp_r.outs_declared,
                           res_if.payload.outs_declared);
                    fail_count++;
                end
            end
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_VERSION:  cfg_version = value[6:0];
            REG_EXTRAS:   cfg_extras = value[10:0];
            REG_OUTPUTS:  cfg_outputs = value[5:0];
            default:      cfg_hardfork = value[7:0];
        endcase
    endtask

    task automatic apb_check(logic [1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 0; paddr <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        if (prdata !== value || pready !== 1'b1) begin
            $error("register %0d exp %0h got %0h", idx, value, prdata);
            fail_count++;
        end
        @(negedge i_clk);
        psel <= 0; penable <= 0;
    endtask

    // send the queued bytes with random gaps
    task automatic send_stream();
        t_in it;
        int gap;
        while (byte_stream.size() > 0) begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) :
                  ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
            repeat (gap) begin
                @(negedge i_clk);
                in_if.valid <= 0;
            end
            it = byte_stream.pop_front();
            @(negedge i_clk);
            in_if.valid <= 1;
            in_if.payload <= it;
            @(posedge i_clk);
            while (!in_if.ready) @(posedge i_clk);
            predict_byte(it);
        end
        @(negedge i_clk);
        in_if.valid <= 0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (pending_results.size() > 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_results.size() > 0) begin
            $display("== FAIL ==");
            $finish;
        end
        repeat (4) @(posedge i_clk);
    endtask

    typedef struct {
        logic [7:0] b;
        logic       last;
        bit         checked;
        logic [3:0] status;
    } t_row;

    t_row directed_rows[$];

    function automatic void row(logic [7:0] b, logic last, bit chk, logic [3:0] st);
        t_row r;
        r.b = b; r.last = last; r.checked = chk; r.status = st;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    initial begin
        t_in it;
        int n_outs;
        int start;
        fail_count = 0; results_seen = 0; prefixes_sent = 0; hold_off = 0;
        in_if.valid = 0; in_if.payload = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        cfg_version = 4; cfg_extras = 1024; cfg_outputs = 32; cfg_hardfork = 6;
        parser_clear();
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        apb_check(REG_VERSION, 4);
        apb_check(REG_OUTPUTS, 32);

        // directed: status readable at a glance
        row(8'hff, 1, 1, ST_TRUNCATED);
        row(8'h05, 1, 1, ST_VERSION);
        row(8'h84, 0, 0, ST_OK);
        row(8'h00, 1, 1, ST_NONCANON);
        for (int k = 0; k < 9; k++) row(8'h80, 0, 0, ST_OK);
        row(8'h80, 1, 1, ST_TOO_LONG);
        for (int k = 0; k < 9; k++) row(8'hff, 0, 0, ST_OK);
        row(8'h02, 1, 1, ST_OVERFLOW);
        row(8'h04, 0, 0, ST_OK);
        row(8'h02, 0, 0, ST_OK);
        row(8'h00, 1, 1, ST_INPUT);
        foreach (directed_rows[i]) begin
            it.data_byte = directed_rows[i].b;
            it.last = directed_rows[i].last;
            byte_stream.insert(byte_stream.size(), it);
            send_stream();
            if (directed_rows[i].checked && pending_results.size() > 0 &&
                pending_results[$].status !== directed_rows[i].status) begin
                $error("status exp %0d got %0d", directed_rows[i].status,
                       pending_results[$].status);
                fail_count++;
            end
        end
        drain();

        // directed prefixes covering the output and hardfork checks
        build_prefix(0, 0); end_prefix();
        build_prefix(0, 2); end_prefix();
        put_varint(4); put_varint(1); put(0); put(0); put(0); put(1); put(7); put(1);
        end_prefix();
        put_varint(4); put_varint(1); put(0); put(0); put(0); put(33); end_prefix();
        put_varint(4); put_varint(1); put(0); put(0); put(0); put(1); put(62); end_prefix();
        put_varint(4); put_varint(1); put(0); put(0); put(0); put(1); put(63); put(1);
        end_prefix();
        build_prefix(0, 0); put(5); end_prefix();
        build_prefix(0, 0); put(0); end_prefix();
        send_stream();
        drain();

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                build_prefix(1, 0); end_prefix();
                send_stream();
            end
            begin
                hold_off = 1;
                repeat (200) @(posedge i_clk);
                hold_off = 0;
            end
        join
        drain();

        // random phases across register settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    apb_write(REG_VERSION, 0); apb_write(REG_EXTRAS, 0);
                    apb_write(REG_OUTPUTS, 0); apb_write(REG_HARDFORK, 0);
                end
                1: begin
                    apb_write(REG_VERSION, 127); apb_write(REG_EXTRAS, 1024);
                    apb_write(REG_OUTPUTS, 63); apb_write(REG_HARDFORK, 255);
                end
                2: begin
                    apb_write(REG_OUTPUTS, 2); apb_write(REG_EXTRAS, 1);
                end
                3: begin
                    apb_write(REG_VERSION, $urandom_range(0, 127));
                    apb_write(REG_EXTRAS, 2047);
                    apb_write(REG_HARDFORK, $urandom_range(0, 255));
                end
                4: begin
                    apb_write(REG_OUTPUTS, 32); apb_write(REG_EXTRAS, 3);
                end
                default: begin
                    apb_write(REG_VERSION, 4); apb_write(REG_HARDFORK, 6);
                end
            endcase
            apb_check(REG_EXTRAS, {21'd0, cfg_extras});
            while (byte_stream.size() < 90) begin
                n_outs = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
                start = byte_stream.size();
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 12)) put(8'($urandom));
                end else begin
                    build_prefix(n_outs, $urandom_range(0, 3));
                    if ($urandom_range(0, 3) == 0) damage_tail(start);
                end
                end_prefix();
                prefixes_sent++;
            end
            send_stream();
            drain();
        end

        $display("covered %0d random prefixes, %0d results checked",
                 prefixes_sent, results_seen);
        if (fail_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
